/* sv/pds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the pll divider search block.
// ----------------------------------------------------------------------------
package pds_pkg;

	// search limits
	localparam int unsigned MAX_NUMERATOR   = 128;
	localparam int unsigned MAX_DENOMINATOR = 32;
	localparam int unsigned MIN_M           = 2;
	localparam int unsigned FULL_P_LAST     = 4;
	localparam int unsigned THR_N_LAST      = 5;
	localparam int unsigned ERR_BOUND       = 42;
	localparam int unsigned TH_HZ           = 353000000;

	// field and datapath widths
	localparam int T_W   = 29;
	localparam int TQ_W  = 45;
	localparam int ERR_W = 51;
	localparam int M_W   = 8;
	localparam int N_W   = 6;
	localparam int P_W   = 4;
	localparam int V_W   = 2;
	localparam int DEN_W = 8;
	localparam int PN_W  = 37;

	// reference and vco limit in hz
	localparam logic [23:0] REF_HZ     = 24'd14318180;
	localparam logic [27:0] VCO_MAX_HZ = 28'd135000000;

	// post scaler thresholds for the threshold search
	localparam logic [T_W-1:0] TH_P2 = T_W'(TH_HZ / 2);
	localparam logic [T_W-1:0] TH_P3 = T_W'(TH_HZ / 3);
	localparam logic [T_W-1:0] TH_P4 = T_W'(TH_HZ / 4);
	localparam logic [T_W-1:0] TH_P6 = T_W'(TH_HZ / 6);
	localparam logic [T_W-1:0] TH_P8 = T_W'(TH_HZ / 8);

	// quotient divider: wide divisor, two bits per cycle
	localparam int QD_W   = 38;
	localparam int QV_W   = 26;
	localparam int Q_W    = 14;
	localparam int Q_STEP = 2;
	localparam int Q_CYC  = Q_W / Q_STEP;
	localparam int QC_W   = 3;

	// frequency divider: narrow divisor, eight bits per cycle
	localparam int X_W    = 48;
	localparam int F_STEP = 8;
	localparam int F_CYC  = X_W / F_STEP;
	localparam int FC_W   = 3;

	typedef struct packed {
		logic [18:0] target_khz;
		logic [1:0]  vld_limit;
	} in_word_t;

	typedef struct packed {
		logic [7:0] numerator;
		logic [5:0] denominator;
		logic [1:0] loop_divider;
		logic [3:0] post_scaler;
		logic       found;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic init;
		logic q_load;
		logic q_take;
		logic f_load;
		logic f_take;
		logic m_inc;
		logic adv;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic no_search;
		logic mode;
		logic q_skip;
		logic t_skip;
		logic m_over;
		logic m_low;
		logic vco_over;
		logic last;
		logic q_done;
		logic f_done;
	} sts_t;

endpackage
`default_nettype wire

/* sv/pds_qdiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_qdiv
// Restoring divider for the multiplier estimate, two quotient bits a cycle.
// ----------------------------------------------------------------------------
module pds_qdiv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic [pds_pkg::QD_W-1:0]  dividend,
	input  wire logic [pds_pkg::QV_W-1:0]  divisor,
	output logic      [pds_pkg::Q_W-1:0]   quotient,
	output logic                           done
);

	logic [pds_pkg::QV_W-1:0] rem_q, rem_n, rem_v;
	logic [pds_pkg::QV_W-1:0] dvs_q;
	logic [pds_pkg::Q_W-1:0]  sh_q, sh_n, sh_v;
	logic [pds_pkg::QC_W-1:0] cnt_q;
	logic [pds_pkg::QV_W:0]   trial;

	// step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pds_pkg::QC_W'(pds_pkg::Q_CYC);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= pds_pkg::QV_W'(dividend[pds_pkg::QD_W-1:pds_pkg::Q_W]);
			sh_q  <= dividend[pds_pkg::Q_W-1:0];
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			sh_q  <= sh_n;
		end
	end

	// two restoring steps
	always_comb begin
		rem_v = rem_q;
		sh_v  = sh_q;
		trial = '0;
		for (int i = 0; i < pds_pkg::Q_STEP; i++) begin
			trial = {rem_v, sh_v[pds_pkg::Q_W-1]};
			if (trial >= {1'b0, dvs_q}) begin
				rem_v = pds_pkg::QV_W'(trial - {1'b0, dvs_q});
				sh_v  = {sh_v[pds_pkg::Q_W-2:0], 1'b1};
			end else begin
				rem_v = trial[pds_pkg::QV_W-1:0];
				sh_v  = {sh_v[pds_pkg::Q_W-2:0], 1'b0};
			end
		end
		rem_n = rem_v;
		sh_n  = sh_v;
	end

	assign quotient = sh_q;
	assign done     = (cnt_q == pds_pkg::QC_W'(1));

endmodule
`default_nettype wire

/* sv/pds_fdiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_fdiv
// Output frequency divider by n*p, eight quotient bits a cycle.
// ----------------------------------------------------------------------------
module pds_fdiv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic [pds_pkg::X_W-1:0]   dividend,
	input  wire logic [pds_pkg::DEN_W-1:0] divisor,
	output logic      [pds_pkg::X_W-1:0]   quotient,
	output logic                           done
);

	logic [pds_pkg::DEN_W-1:0] rem_q, rem_n, rem_v;
	logic [pds_pkg::DEN_W-1:0] dvs_q;
	logic [pds_pkg::X_W-1:0]   sh_q, sh_n, sh_v;
	logic [pds_pkg::FC_W-1:0]  cnt_q;
	logic [pds_pkg::DEN_W:0]   trial;

	// step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pds_pkg::FC_W'(pds_pkg::F_CYC);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			sh_q  <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			sh_q  <= sh_n;
		end
	end

	// eight restoring steps on a narrow remainder
	always_comb begin
		rem_v = rem_q;
		sh_v  = sh_q;
		trial = '0;
		for (int i = 0; i < pds_pkg::F_STEP; i++) begin
			trial = {rem_v, sh_v[pds_pkg::X_W-1]};
			if (trial >= {1'b0, dvs_q}) begin
				rem_v = pds_pkg::DEN_W'(trial - {1'b0, dvs_q});
				sh_v  = {sh_v[pds_pkg::X_W-2:0], 1'b1};
			end else begin
				rem_v = trial[pds_pkg::DEN_W-1:0];
				sh_v  = {sh_v[pds_pkg::X_W-2:0], 1'b0};
			end
		end
		rem_n = rem_v;
		sh_n  = sh_v;
	end

	assign quotient = sh_q;
	assign done     = (cnt_q == pds_pkg::FC_W'(1));

endmodule
`default_nettype wire

/* sv/pds_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_datapath
// Loop counters, candidate arithmetic, dividers and best-candidate registers.
// ----------------------------------------------------------------------------
module pds_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire pds_pkg::in_word_t  item,
	input  wire pds_pkg::cmd_t      cmd,
	output pds_pkg::sts_t           sts,
	output pds_pkg::out_word_t      result
);

	logic                          chip_mode_q;
	logic                          mode_q;
	logic [pds_pkg::T_W-1:0]       t_q;
	logic [pds_pkg::V_W-1:0]       vmax_q, vld_q, bv_q;
	logic [pds_pkg::N_W-1:0]       n_q, bn_q;
	logic [pds_pkg::P_W-1:0]       p_q, bp_q;
	logic [pds_pkg::DEN_W-1:0]     den_q;
	logic [pds_pkg::M_W-1:0]       m_q, hi_q, bm_q;
	logic [pds_pkg::ERR_W-1:0]     best_err_q;
	logic                          found_q;

	logic [pds_pkg::T_W-1:0]       t_in;
	logic [pds_pkg::V_W-1:0]       vmax_in;
	logic [pds_pkg::P_W-1:0]       p_thr;
	logic [34:0]                   e0;
	logic [pds_pkg::PN_W-1:0]      num;
	logic                          over1;
	logic [pds_pkg::QD_W-1:0]      q_dividend;
	logic [pds_pkg::QV_W-1:0]      q_divisor;
	logic [pds_pkg::Q_W-1:0]       q;
	logic                          q_done;
	logic [pds_pkg::Q_W-1:0]       lo, lo_c, hi;
	logic [8:0]                    mv;
	logic [31:0]                   ref_mv;
	logic [33:0]                   vco_lim;
	logic [pds_pkg::X_W-1:0]       f, tq, err;
	logic                          f_done;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_mode_q <= 1'b0;
		end else if (cfg_we) begin
			chip_mode_q <= cfg_wdata;
		end
	end

	// input word decode
	always_comb begin
		t_in    = pds_pkg::T_W'(32'(item.target_khz) * 32'd1000);
		vmax_in = (item.vld_limit == 2'd3) ? 2'd2 : item.vld_limit;
		e0      = 35'(item.target_khz) * 35'(pds_pkg::ERR_BOUND * 1000);
		p_thr   = 4'd1;
		if (t_in < pds_pkg::TH_P2) p_thr = 4'd2;
		if (t_in < pds_pkg::TH_P3) p_thr = 4'd3;
		if (t_in < pds_pkg::TH_P4) p_thr = 4'd4;
		if (t_in < pds_pkg::TH_P6) p_thr = 4'd6;
		if (t_in < pds_pkg::TH_P8) p_thr = 4'd8;
	end

	// multiplier estimate operands
	always_comb begin
		num   = pds_pkg::PN_W'(t_q) * pds_pkg::PN_W'(den_q);
		over1 = num > pds_pkg::PN_W'(pds_pkg::MAX_NUMERATOR) * pds_pkg::PN_W'(pds_pkg::REF_HZ);
		if (!mode_q) begin
			q_dividend = pds_pkg::QD_W'(num);
			q_divisor  = (vld_q == 2'd2) ? pds_pkg::QV_W'({pds_pkg::REF_HZ, 1'b0})
			                             : pds_pkg::QV_W'(pds_pkg::REF_HZ);
		end else if (over1) begin
			q_dividend = pds_pkg::QD_W'(num) + pds_pkg::QD_W'(pds_pkg::REF_HZ);
			q_divisor  = pds_pkg::QV_W'({pds_pkg::REF_HZ, 2'b00});
		end else begin
			q_dividend = pds_pkg::QD_W'({num, 1'b0}) + pds_pkg::QD_W'(pds_pkg::REF_HZ);
			q_divisor  = pds_pkg::QV_W'({pds_pkg::REF_HZ, 1'b0});
		end
	end

	pds_qdiv u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.q_load),
		.dividend (q_dividend),
		.divisor  (q_divisor),
		.quotient (q),
		.done     (q_done)
	);

	// m window around the estimate
	always_comb begin
		lo   = q - 1'b1;
		lo_c = (lo < pds_pkg::Q_W'(pds_pkg::MIN_M)) ? pds_pkg::Q_W'(pds_pkg::MIN_M) : lo;
		hi   = (q + 1'b1 > pds_pkg::Q_W'(pds_pkg::MAX_NUMERATOR))
		       ? pds_pkg::Q_W'(pds_pkg::MAX_NUMERATOR) : q + 1'b1;
	end

	// candidate vco and frequency numerator
	always_comb begin
		mv      = (vld_q == 2'd2) ? {m_q, 1'b0} : {1'b0, m_q};
		ref_mv  = 32'(pds_pkg::REF_HZ) * 32'(mv);
		vco_lim = 34'(pds_pkg::VCO_MAX_HZ) * 34'(n_q);
	end

	pds_fdiv u_fdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.f_load),
		.dividend ({ref_mv, 16'b0}),
		.divisor  (den_q),
		.quotient (f),
		.done     (f_done)
	);

	// error of the candidate
	always_comb begin
		tq  = pds_pkg::X_W'({t_q, 16'b0});
		err = (tq >= f) ? tq - f : f - tq;
	end

	// loop counters and search state
	always_ff @(posedge clk) begin
		den_q <= pds_pkg::DEN_W'(n_q * p_q);
		if (cmd.init) begin
			mode_q <= chip_mode_q;
			t_q    <= t_in;
			vmax_q <= vmax_in;
			vld_q  <= 2'd1;
			n_q    <= pds_pkg::N_W'(2);
			p_q    <= chip_mode_q ? p_thr : 4'd1;
		end else if (cmd.adv) begin
			if (mode_q) begin
				n_q <= n_q + 1'b1;
			end else if (p_q != pds_pkg::P_W'(pds_pkg::FULL_P_LAST)) begin
				p_q <= p_q + 1'b1;
			end else begin
				p_q <= 4'd1;
				if (n_q != pds_pkg::N_W'(pds_pkg::MAX_DENOMINATOR)) begin
					n_q <= n_q + 1'b1;
				end else begin
					n_q   <= pds_pkg::N_W'(2);
					vld_q <= vld_q + 1'b1;
				end
			end
		end else if (cmd.q_load && mode_q) begin
			vld_q <= over1 ? 2'd2 : 2'd1;
		end

		if (cmd.q_take) begin
			m_q  <= mode_q ? pds_pkg::M_W'(q) : pds_pkg::M_W'(lo_c);
			hi_q <= pds_pkg::M_W'(hi);
		end else if (cmd.m_inc) begin
			m_q <= m_q + 1'b1;
		end
	end

	// best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.init) begin
			found_q <= 1'b0;
		end else if (cmd.f_take && (pds_pkg::ERR_W'(err) < best_err_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			best_err_q <= {e0, 16'b0};
			bm_q       <= '0;
			bn_q       <= '0;
			bv_q       <= '0;
			bp_q       <= '0;
		end else if (cmd.f_take && (pds_pkg::ERR_W'(err) < best_err_q)) begin
			best_err_q <= pds_pkg::ERR_W'(err);
			bm_q       <= m_q;
			bn_q       <= n_q;
			bv_q       <= vld_q;
			bp_q       <= p_q;
		end
	end

	// status to the controller
	always_comb begin
		sts.no_search = (t_q == '0) || (vmax_q == '0);
		sts.mode      = mode_q;
		sts.q_skip    = (q == '0) || (q > pds_pkg::Q_W'(pds_pkg::MAX_NUMERATOR + 1));
		sts.t_skip    = (vmax_q == 2'd2)
		                ? (num > pds_pkg::PN_W'(pds_pkg::MAX_NUMERATOR * 2)
		                         * pds_pkg::PN_W'(pds_pkg::REF_HZ))
		                : over1;
		sts.m_over    = !mode_q && (m_q > hi_q);
		sts.m_low     = !mode_q && (mv <= 9'(n_q));
		sts.vco_over  = !mode_q && ({2'b00, ref_mv} > vco_lim);
		sts.last      = mode_q ? (n_q == pds_pkg::N_W'(pds_pkg::THR_N_LAST))
		                       : ((vld_q == vmax_q)
		                          && (n_q == pds_pkg::N_W'(pds_pkg::MAX_DENOMINATOR))
		                          && (p_q == pds_pkg::P_W'(pds_pkg::FULL_P_LAST)));
		sts.q_done    = q_done;
		sts.f_done    = f_done;
	end

	// result word
	assign result.numerator    = bm_q;
	assign result.denominator  = bn_q;
	assign result.loop_divider = bv_q;
	assign result.post_scaler  = bp_q;
	assign result.found        = found_q;

endmodule
`default_nettype wire

/* sv/pds_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_ctrl
// Search sequencer: walks the candidate loops and drives the datapath.
// ----------------------------------------------------------------------------
module pds_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire pds_pkg::sts_t  sts,
	output pds_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_INIT   = 11'b000_0000_0010,
		S_PREP   = 11'b000_0000_0100,
		S_QLOAD  = 11'b000_0000_1000,
		S_QWAIT  = 11'b000_0001_0000,
		S_QTAKE  = 11'b000_0010_0000,
		S_MCHECK = 11'b000_0100_0000,
		S_FWAIT  = 11'b000_1000_0000,
		S_FTAKE  = 11'b001_0000_0000,
		S_ADV    = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.init = 1'b1;
					state_n  = S_INIT;
				end
			end
			S_INIT: begin
				state_n = sts.no_search ? S_DONE : S_QLOAD;
			end
			S_PREP: begin
				state_n = S_QLOAD;
			end
			S_QLOAD: begin
				if (sts.mode && sts.t_skip) begin
					state_n = S_ADV;
				end else begin
					cmd.q_load = 1'b1;
					state_n    = S_QWAIT;
				end
			end
			S_QWAIT: begin
				if (sts.q_done) state_n = S_QTAKE;
			end
			S_QTAKE: begin
				if (!sts.mode && sts.q_skip) begin
					state_n = S_ADV;
				end else begin
					cmd.q_take = 1'b1;
					state_n    = S_MCHECK;
				end
			end
			S_MCHECK: begin
				if (sts.m_over) begin
					state_n = S_ADV;
				end else if (sts.m_low) begin
					cmd.m_inc = 1'b1;
				end else if (sts.vco_over) begin
					state_n = S_ADV;
				end else begin
					cmd.f_load = 1'b1;
					state_n    = S_FWAIT;
				end
			end
			S_FWAIT: begin
				if (sts.f_done) state_n = S_FTAKE;
			end
			S_FTAKE: begin
				cmd.f_take = 1'b1;
				if (sts.mode) begin
					state_n = S_ADV;
				end else begin
					cmd.m_inc = 1'b1;
					state_n   = S_MCHECK;
				end
			end
			S_ADV: begin
				if (sts.last) begin
					state_n = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_n = S_PREP;
				end
			end
			S_DONE: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

/* sv/pll_divider_search_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pll_divider_search_top
// Searches m, n, loop divider and post scaler for the output clock nearest
// to the requested target.
// ----------------------------------------------------------------------------
// latency in mode 0 comes from the quotient divider, run once per (vld, n, p)
//   combination, and the frequency divider, run once per m candidate
// in mode 1 at most four candidates per word, one per n, go through the dividers
// throughput: one word at a time, start is taken only while busy is low
// result is shown for one cycle with done; the receiver cannot stall
// reset: asynchronous, returns to idle with chip_mode at 0
module pll_divider_search_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire pds_pkg::in_word_t  item,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	output logic                    done,
	output pds_pkg::out_word_t      result
);

	pds_pkg::cmd_t cmd;
	pds_pkg::sts_t sts;

	// sequencer
	pds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// arithmetic and best-candidate tracking
	pds_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule
`default_nettype wire
